[src/llgr_pkg.sv]
// shared types and constants for the linked list group reverse block
// no dependencies; used by the interfaces, the top level and the checker
`default_nettype none
package llgr_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = 10;
	localparam int DATA_W      = 32;
	localparam int LINK_W      = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int NODES_DEF   = 1024;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_HEAD  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GROUP = CFG_IDX_W'(1);

	// item function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_FETCH = 1'b1;

	localparam logic signed [LINK_W-1:0] LINK_NONE = '1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_CHECK,
		S_RD_NXT,
		S_OUT
	} state_t;

endpackage
`default_nettype wire

[src/llgr_item_if.sv]
// input item channel: load or fetch command with node payload
// depends on llgr_pkg
`default_nettype none
interface llgr_item_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   func;
	logic [llgr_pkg::ADDR_W-1:0]            node_addr;
	logic signed [llgr_pkg::DATA_W-1:0]     node_data;
	logic signed [llgr_pkg::LINK_W-1:0]     succ_addr;

	modport source (output valid, func, node_addr, node_data, succ_addr, input ready);
	modport sink   (input valid, func, node_addr, node_data, succ_addr, output ready);
endinterface
`default_nettype wire

[src/llgr_result_if.sv]
// result channel: one node of the reordered list per transaction
// depends on llgr_pkg
`default_nettype none
interface llgr_result_if;
	logic                                   valid;
	logic                                   ready;
	logic [llgr_pkg::ADDR_W-1:0]            out_addr;
	logic signed [llgr_pkg::DATA_W-1:0]     out_data;
	logic signed [llgr_pkg::LINK_W-1:0]     out_succ;
	logic                                   is_last;
	logic                                   list_empty;

	modport source (output valid, out_addr, out_data, out_succ, is_last, list_empty,
		input ready);
	modport sink   (input valid, out_addr, out_data, out_succ, is_last, list_empty,
		output ready);
endinterface
`default_nettype wire

[src/llgr_cfg_if.sv]
// configuration write channel: register index and write data
// depends on llgr_pkg
`default_nettype none
interface llgr_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [llgr_pkg::CFG_IDX_W-1:0]         index;
	logic [llgr_pkg::LINK_W-1:0]            data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/llgr_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none
module llgr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[src/linked_list_group_reverse.sv]
// Linked list group reverse, top level.
// depends on llgr_pkg, llgr_item_if, llgr_result_if, llgr_cfg_if and llgr_ram
//
// Usage:
//  - cfg channel writes head_addr (index 0, -1 for an empty list) and group_size
//    (index 1, 0 acts as 1); other indexes are ignored. Either write, and any load,
//    makes the next fetch rebuild the order. While a cfg write is offered the
//    item channel is held off, so the two are never accepted together.
//  - item channel: func 0 loads one node (data and successor) into the node
//    table and gives no result; func 1 fetches the next node of the reordered list.
//  - result channel: one transaction per fetch. An empty list gives a flagged
//    empty result on every fetch; a fetch past the last node gives none.
// Load and fetch sequence:
//  - items are accepted only in the idle state
//  - a fetch steps through an order ram read, then node ram and next-order
//    ram reads, then the output register, one fetch at a time
//  - the first fetch after a load or a head or group write first walks the chain
//    through the node ram at one node per cycle, until the end of the chain
//    or NODES nodes
// Reset clears the control state (head -1, group size 1, order not built);
// the node tables are undefined until loaded. The result register holds its
// transaction while the receiver stalls; loads are still accepted then, and
// a fetch waits in its last step until the register frees.
`default_nettype none
module linked_list_group_reverse #(
	parameter int NODES = llgr_pkg::NODES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	llgr_item_if.sink       item,
	llgr_result_if.source   result,
	llgr_cfg_if.sink        cfg
);

	localparam int PW = $clog2(NODES + 1);
	localparam int IW = $clog2(NODES);
	localparam int SW = ((PW > llgr_pkg::LINK_W) ? PW : llgr_pkg::LINK_W) + 1;
	localparam int AW = llgr_pkg::ADDR_W;
	localparam int LW = llgr_pkg::LINK_W;
	localparam int DW = llgr_pkg::DATA_W;

	llgr_pkg::state_t state_q, state_d;

	logic signed [LW-1:0] head_q;
	logic [LW-1:0]        group_q;
	logic [LW-1:0]        k_q;
	logic                 built_q;
	logic                 first_q;
	logic [PW-1:0]        len_q;
	logic [PW-1:0]        pos_q;
	logic [PW-1:0]        base_q;
	logic [PW-1:0]        off_q;
	logic [AW-1:0]        cur_addr_q;

	logic                 out_valid_q;
	logic [AW-1:0]        out_addr_q;
	logic [DW-1:0]        out_data_q;
	logic [LW-1:0]        out_succ_q;
	logic                 out_last_q;
	logic                 out_empty_q;

	// ram ports
	logic             tab_we;
	logic             succ_re;
	logic             data_re;
	logic             node_re;
	logic [AW-1:0]    node_raddr;
	logic [DW+LW-1:0] node_rd;
	logic [LW-1:0]    succ_rd;
	logic [DW-1:0]    data_rd;
	logic             ord_we;
	logic             ord_re;
	logic [IW-1:0]    ord_raddr;
	logic [AW-1:0]    ord_rd;

	logic          item_acc;
	logic          cfg_acc;
	logic          cfg_hit;
	logic          order_clr;
	logic          out_free;
	logic          walk_neg;
	logic [AW-1:0] walk_addr;
	logic          walk_stop;
	logic          has_next;
	logic          list_none;
	logic [PW-1:0] nbase;
	logic [PW-1:0] noff;
	logic [IW-1:0] map_cur;
	logic [IW-1:0] map_nxt;

	// position of (group base, offset) in the walk order, reversed in full groups
	function automatic logic [IW-1:0] map_pos(input logic [SW-1:0] base,
		input logic [SW-1:0] off, input logic [SW-1:0] k, input logic [SW-1:0] len);
		logic [SW-1:0] top;
		logic [SW-1:0] idx;
		top = base + k;
		if (top <= len) begin
			idx = top - SW'(1) - off;
		end else begin
			idx = base + off;
		end
		return idx[IW-1:0];
	endfunction

	assign item_acc  = item.valid && item.ready;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign cfg_hit   = (cfg.index == llgr_pkg::REG_HEAD) || (cfg.index == llgr_pkg::REG_GROUP);
	assign out_free  = !out_valid_q || result.ready;
	assign list_none = (len_q == '0);

	assign walk_neg  = first_q ? head_q[LW-1] : succ_rd[LW-1];
	assign walk_addr = first_q ? head_q[AW-1:0] : succ_rd[AW-1:0];
	assign walk_stop = walk_neg || (len_q == PW'(NODES));

	assign has_next  = ({1'b0, pos_q} + (PW+1)'(1)) < {1'b0, len_q};

	always_comb begin
		if ((SW'(off_q) + SW'(1)) == SW'(k_q)) begin
			nbase = PW'(SW'(base_q) + SW'(k_q));
			noff  = '0;
		end else begin
			nbase = base_q;
			noff  = off_q + PW'(1);
		end
	end

	assign map_cur = map_pos(SW'(base_q), SW'(off_q), SW'(k_q), SW'(len_q));
	assign map_nxt = map_pos(SW'(nbase), SW'(noff), SW'(k_q), SW'(len_q));

	assign tab_we    = item_acc && (item.func == llgr_pkg::FUNC_LOAD);
	assign order_clr = (cfg_acc && cfg_hit) || tab_we;

	// one node ram serves the walk (successor) and the read-out (data)
	assign node_re    = succ_re || data_re;
	assign node_raddr = data_re ? ord_rd : walk_addr;
	assign succ_rd    = node_rd[LW-1:0];
	assign data_rd    = node_rd[DW+LW-1:LW];

	// next state and ram controls
	always_comb begin
		state_d    = state_q;
		succ_re    = 1'b0;
		ord_we     = 1'b0;
		ord_re     = 1'b0;
		ord_raddr  = map_cur;
		data_re    = 1'b0;
		case (state_q)
			llgr_pkg::S_IDLE: begin
				if (item_acc && (item.func == llgr_pkg::FUNC_FETCH)) begin
					state_d = built_q ? llgr_pkg::S_CHECK : llgr_pkg::S_WALK;
				end
			end
			llgr_pkg::S_WALK: begin
				if (walk_stop) begin
					state_d = llgr_pkg::S_CHECK;
				end else begin
					succ_re = 1'b1;
					ord_we  = 1'b1;
				end
			end
			llgr_pkg::S_CHECK: begin
				if (list_none) begin
					state_d = llgr_pkg::S_OUT;
				end else if (pos_q >= len_q) begin
					state_d = llgr_pkg::S_IDLE;
				end else begin
					ord_re  = 1'b1;
					state_d = llgr_pkg::S_RD_NXT;
				end
			end
			llgr_pkg::S_RD_NXT: begin
				data_re   = 1'b1;
				ord_re    = has_next;
				ord_raddr = map_nxt;
				state_d   = llgr_pkg::S_OUT;
			end
			llgr_pkg::S_OUT: begin
				if (out_free) begin
					state_d = llgr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = llgr_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= llgr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= llgr_pkg::LINK_NONE;
			group_q     <= LW'(1);
			k_q         <= LW'(1);
			built_q     <= 1'b0;
			first_q     <= 1'b0;
			len_q       <= '0;
			pos_q       <= '0;
			base_q      <= '0;
			off_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_acc && cfg_hit) begin
				if (cfg.index == llgr_pkg::REG_HEAD) begin
					head_q <= cfg.data;
				end else begin
					group_q <= cfg.data;
				end
			end
			// read-out position is already zero whenever the order is not built
			if (order_clr) begin
				built_q <= 1'b0;
				pos_q   <= '0;
				base_q  <= '0;
				off_q   <= '0;
			end
			if ((state_q == llgr_pkg::S_IDLE) && item_acc
				&& (item.func == llgr_pkg::FUNC_FETCH) && !built_q) begin
				len_q   <= '0;
				first_q <= 1'b1;
				k_q     <= (group_q == '0) ? LW'(1) : group_q;
			end
			if (state_q == llgr_pkg::S_WALK) begin
				if (walk_stop) begin
					built_q <= 1'b1;
				end else begin
					len_q   <= len_q + PW'(1);
					first_q <= 1'b0;
				end
			end
			if ((state_q == llgr_pkg::S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
				if (!list_none) begin
					pos_q  <= pos_q + PW'(1);
					base_q <= nbase;
					off_q  <= noff;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == llgr_pkg::S_RD_NXT) begin
			cur_addr_q <= ord_rd;
		end
		if ((state_q == llgr_pkg::S_OUT) && out_free) begin
			if (list_none) begin
				out_addr_q  <= '0;
				out_data_q  <= '0;
				out_succ_q  <= llgr_pkg::LINK_NONE;
				out_last_q  <= 1'b1;
				out_empty_q <= 1'b1;
			end else begin
				out_addr_q  <= cur_addr_q;
				out_data_q  <= data_rd;
				out_succ_q  <= has_next ? {1'b0, ord_rd} : llgr_pkg::LINK_NONE;
				out_last_q  <= !has_next;
				out_empty_q <= 1'b0;
			end
		end
	end

	llgr_ram #(.WIDTH(DW + LW), .DEPTH(llgr_pkg::TABLE_DEPTH)) u_node_ram (
		.clk   (clk),
		.we    (tab_we),
		.waddr (item.node_addr),
		.wdata ({item.node_data, item.succ_addr}),
		.re    (node_re),
		.raddr (node_raddr),
		.rdata (node_rd)
	);

	llgr_ram #(.WIDTH(AW), .DEPTH(NODES)) u_order_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (len_q[IW-1:0]),
		.wdata (walk_addr),
		.re    (ord_re),
		.raddr (ord_raddr),
		.rdata (ord_rd)
	);

	assign item.ready = (state_q == llgr_pkg::S_IDLE) && !cfg.valid;
	assign cfg.ready  = (state_q == llgr_pkg::S_IDLE);

	assign result.valid      = out_valid_q;
	assign result.out_addr   = out_addr_q;
	assign result.out_data   = out_data_q;
	assign result.out_succ   = out_succ_q;
	assign result.is_last    = out_last_q;
	assign result.list_empty = out_empty_q;

endmodule
`default_nettype wire

[src/llgr_checker.sv]
// port-level checker for linked_list_group_reverse, attached by bind
// depends on llgr_pkg and the channel interfaces of the top level
`default_nettype none
module llgr_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 i_valid,
	input wire logic                                 i_ready,
	input wire logic                                 i_func,
	input wire logic                                 r_valid,
	input wire logic                                 r_ready,
	input wire logic [llgr_pkg::ADDR_W-1:0]          r_addr,
	input wire logic signed [llgr_pkg::DATA_W-1:0]   r_data,
	input wire logic signed [llgr_pkg::LINK_W-1:0]   r_succ,
	input wire logic                                 r_last,
	input wire logic                                 r_empty
);

	// a stalled result transaction stays offered
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid)
		else $error("result dropped while stalled");

	// the last-node flag and the end link agree
	a_last_link: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> (r_last == (r_succ == llgr_pkg::LINK_NONE)))
		else $error("is_last and out_succ disagree");

	// empty list result is fully flagged and zeroed
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_empty |-> r_last && (r_addr == '0) && (r_data == '0))
		else $error("malformed empty result");

	// a load transaction never creates a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		i_valid && i_ready && (i_func == llgr_pkg::FUNC_LOAD) && !r_valid |=> !r_valid)
		else $error("result appeared after a load");

endmodule

bind linked_list_group_reverse llgr_checker u_llgr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.i_valid (item.valid),
	.i_ready (item.ready),
	.i_func  (item.func),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_addr  (result.out_addr),
	.r_data  (result.out_data),
	.r_succ  (result.out_succ),
	.r_last  (result.is_last),
	.r_empty (result.list_empty)
);
`default_nettype wire

[verif/llgr_order_checker.sv]
`timescale 1ns / 100ps
// checker for linked_list_group_reverse: mirrors the node tables and registers,
// rebuilds the group-reversed order and compares every result transaction
// depends on llgr_pkg and the item, result and cfg channel interfaces
module llgr_order_checker
	import llgr_pkg::*;
#(
	parameter int WALK_MAX = NODES_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	llgr_item_if   item,
	llgr_result_if result,
	llgr_cfg_if    cfg,
	output int     errors,
	output int     pending
);

	typedef struct {
		logic [ADDR_W-1:0]        addr;
		logic signed [DATA_W-1:0] data;
		logic signed [LINK_W-1:0] succ;
		logic                     last;
		logic                     empty;
	} node_out_t;

	logic [DATA_W-1:0] data_mem  [TABLE_DEPTH];
	logic [LINK_W-1:0] link_mem  [TABLE_DEPTH];
	logic [ADDR_W-1:0] order_mem [WALK_MAX];
	int                order_len;
	int                rd_pos;
	bit                built;
	logic [LINK_W-1:0] head_reg;
	logic [LINK_W-1:0] grp_reg;
	node_out_t         expected_nodes [$];
	int                mism_cnt;

	assign errors = mism_cnt;

	// follow the chain from the head, then reverse every full group in place
	function automatic void rebuild_order();
		logic [LINK_W-1:0] cur;
		logic [ADDR_W-1:0] swap;
		int                k;
		int                lo;
		int                hi;
		cur = head_reg;
		order_len = 0;
		while (!cur[LINK_W-1] && order_len < WALK_MAX) begin
			order_mem[order_len] = cur[ADDR_W-1:0];
			order_len++;
			cur = link_mem[cur[ADDR_W-1:0]];
		end
		k = (grp_reg == '0) ? 1 : int'(grp_reg);
		for (int base = 0; base + k <= order_len; base += k) begin
			lo = base;
			hi = base + k - 1;
			while (lo < hi) begin
				swap = order_mem[lo];
				order_mem[lo] = order_mem[hi];
				order_mem[hi] = swap;
				lo++;
				hi--;
			end
		end
		rd_pos = 0;
		built = 1'b1;
	endfunction

	function automatic void cmp_field(string name, logic [DATA_W-1:0] got,
		logic [DATA_W-1:0] want);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mism_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		node_out_t want;
		if (!arst_n) begin
			expected_nodes.delete();
			order_len = 0;
			rd_pos = 0;
			built = 1'b0;
			head_reg = LINK_NONE;
			grp_reg = LINK_W'(1);
			mism_cnt = 0;
			pending = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_nodes.size() == 0) begin
					$display("%0t: result transaction, expected none, got addr %0h data %0h",
						$time, result.out_addr, result.out_data);
					mism_cnt++;
				end else begin
					want = expected_nodes.pop_front();
					cmp_field("out_addr", result.out_addr, want.addr);
					cmp_field("out_data", result.out_data, want.data);
					cmp_field("out_succ", result.out_succ, want.succ);
					cmp_field("is_last", result.is_last, want.last);
					cmp_field("list_empty", result.list_empty, want.empty);
				end
			end
			if (item.valid && item.ready) begin
				if (item.func == FUNC_LOAD) begin
					data_mem[item.node_addr] = item.node_data;
					link_mem[item.node_addr] = item.succ_addr;
					built = 1'b0;
					rd_pos = 0;
				end else begin
					if (!built)
						rebuild_order();
					if (order_len == 0) begin
						want.addr = '0;
						want.data = '0;
						want.succ = LINK_NONE;
						want.last = 1'b1;
						want.empty = 1'b1;
						expected_nodes = {expected_nodes, want};
					end else if (rd_pos < order_len) begin
						want.addr = order_mem[rd_pos];
						want.data = data_mem[want.addr];
						if (rd_pos + 1 < order_len) begin
							want.succ = {1'b0, order_mem[rd_pos + 1]};
							want.last = 1'b0;
						end else begin
							want.succ = LINK_NONE;
							want.last = 1'b1;
						end
						want.empty = 1'b0;
						expected_nodes = {expected_nodes, want};
						rd_pos++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_HEAD) begin
					head_reg = cfg.data;
					built = 1'b0;
					rd_pos = 0;
				end else if (cfg.index == REG_GROUP) begin
					grp_reg = cfg.data;
					built = 1'b0;
					rd_pos = 0;
				end
			end
			pending = expected_nodes.size();
		end
	end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// top of the linked_list_group_reverse testbench: clock, reset, list stimulus and verdict
// depends on llgr_pkg, the channel interfaces, llgr_order_checker and the block
module tb;
	import llgr_pkg::*;

	localparam int CYCLE_LIMIT   = 1500000;
	localparam int SETTLE_CYCLES = NODES_DEF + 16;
	localparam int RANDOM_ITEMS  = 950;
	// indexes past the register list; writes there must leave the block untouched
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   items_sent;
	int   cycle_cnt = 0;
	int   fail_cnt;
	int   pending;

	// nodes of the list under test; loads outside the chain never touch these
	bit                on_chain   [TABLE_DEPTH];
	logic [ADDR_W-1:0] chain_addr [TABLE_DEPTH];
	logic [LINK_W-1:0] chain_link [TABLE_DEPTH];

	llgr_item_if   item_ch ();
	llgr_result_if res_ch ();
	llgr_cfg_if    cfg_ch ();

	linked_list_group_reverse DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	llgr_order_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (res_ch),
		.cfg     (cfg_ch),
		.errors  (fail_cnt),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("linked_list_group_reverse test failed");
			$finish;
		end
	end

	// valid is left high on return; the next transaction or settle() decides it
	task automatic send_item(logic func, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
		logic [LINK_W-1:0] link);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.func      <= func;
		item_ch.node_addr <= addr;
		item_ch.node_data <= data;
		item_ch.succ_addr <= link;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic fetch_next(int n);
		repeat (n) send_item(FUNC_FETCH, ADDR_W'($urandom), $urandom, LINK_W'($urandom));
	endtask

	task automatic noise_load();
		logic [ADDR_W-1:0] a;
		do a = ADDR_W'($urandom); while (on_chain[a]);
		send_item(FUNC_LOAD, a, $urandom, LINK_W'($urandom));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LINK_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// no result outstanding, then room for a full chain walk to finish
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_episode(int len, logic [LINK_W-1:0] grp, bit cyclic, bit no_head,
		bit spare_write);
		int n_fetch;
		int pick;
		int j;
		settle();
		foreach (on_chain[i]) on_chain[i] = 1'b0;
		for (int i = 0; i < len; i++) begin
			do chain_addr[i] = ADDR_W'($urandom); while (on_chain[chain_addr[i]]);
			on_chain[chain_addr[i]] = 1'b1;
		end
		for (int i = 0; i < len - 1; i++) chain_link[i] = {1'b0, chain_addr[i + 1]};
		if (cyclic)
			chain_link[len - 1] = {1'b0, chain_addr[$urandom_range(0, len - 1)]};
		else if ($urandom_range(0, 3) == 0)
			chain_link[len - 1] = {1'b1, ADDR_W'($urandom)};
		else
			chain_link[len - 1] = LINK_NONE;
		write_reg(REG_HEAD, no_head ? {1'b1, ADDR_W'($urandom)} : {1'b0, chain_addr[0]});
		write_reg(REG_GROUP, grp);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 15)
				noise_load();
			send_item(FUNC_LOAD, chain_addr[i], $urandom, chain_link[i]);
		end
		n_fetch = cyclic ? len + 6 : len + $urandom_range(0, 2);
		for (int i = 0; i < n_fetch; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				// fresh data on a chain node restarts the read-out
				j = $urandom_range(0, len - 1);
				send_item(FUNC_LOAD, chain_addr[j], $urandom, chain_link[j]);
			end else if (pick < 10) begin
				noise_load();
			end
			if (spare_write && i == n_fetch / 2) begin
				settle();
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, LINK_W'($urandom));
			end
			fetch_next(1);
		end
	endtask

	initial begin
		int                len;
		int                roll;
		int                dir_items;
		bit                cyclic;
		bit                no_head;
		logic [LINK_W-1:0] grp;
		arst_n            = 1'b0;
		item_ch.valid     = 1'b0;
		item_ch.func      = FUNC_LOAD;
		item_ch.node_addr = '0;
		item_ch.node_data = '0;
		item_ch.succ_addr = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = REG_HEAD;
		cfg_ch.data       = '0;
		res_ch.ready      = 1'b0;
		send_idle_pct     = 18;
		recv_stall_pct    = 46;
		items_sent        = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// out of reset the head is -1: flagged empty result
		fetch_next(1);
		send_item(FUNC_LOAD, ADDR_W'(0), 32'h7fff_ffff, LINK_W'(TABLE_DEPTH - 1));
		send_item(FUNC_LOAD, ADDR_W'(TABLE_DEPTH - 1), 32'h8000_0000, {1'b1, ADDR_W'(0)});
		settle();
		write_reg(REG_HEAD, '0);
		write_reg(REG_GROUP, LINK_W'(2));
		// third fetch runs past the end of the list
		fetch_next(3);
		settle();
		write_reg(REG_GROUP, '0);
		fetch_next(2);
		settle();
		write_reg(REG_GROUP, '1);
		fetch_next(1);
		settle();
		write_reg(REG_SPARE_A, '1);
		write_reg(REG_SPARE_B, LINK_W'(11'h555));
		fetch_next(2);
		settle();
		write_reg(REG_HEAD, {1'b1, ADDR_W'(0)});
		fetch_next(1);
		// self loop: the walk stops at the node limit
		send_item(FUNC_LOAD, ADDR_W'(5), '0, LINK_W'(5));
		settle();
		write_reg(REG_HEAD, LINK_W'(5));
		write_reg(REG_GROUP, LINK_W'(3));
		fetch_next(4);
		settle();
		write_reg(REG_GROUP, LINK_W'(TABLE_DEPTH));
		fetch_next(2);
		dir_items = items_sent;

		while (items_sent < dir_items + RANDOM_ITEMS) begin
			roll = items_sent - dir_items;
			if (roll < RANDOM_ITEMS / 3) begin
				send_idle_pct = 18;
				recv_stall_pct = 46;
			end else if (roll < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 46;
				recv_stall_pct = 18;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			roll = $urandom_range(0, 99);
			if (roll < 72)
				len = $urandom_range(1, 12);
			else if (roll < 95)
				len = $urandom_range(13, 40);
			else
				len = $urandom_range(41, 80);
			roll = $urandom_range(0, 99);
			cyclic = (roll < 5);
			no_head = (roll >= 5 && roll < 13);
			roll = $urandom_range(0, 99);
			if (roll < 60)
				grp = LINK_W'($urandom_range(1, len + 1));
			else if (roll < 68)
				grp = '0;
			else if (roll < 76)
				grp = LINK_W'(TABLE_DEPTH);
			else if (roll < 82)
				grp = '1;
			else
				grp = LINK_W'($urandom);
			run_episode(len, grp, cyclic, no_head, $urandom_range(0, 99) < 15);
		end

		settle();
		if (fail_cnt == 0 && pending == 0)
			$display("linked_list_group_reverse test passed");
		else
			$display("linked_list_group_reverse test failed");
		$finish;
	end

endmodule

[linked_list_group_reverse.f]
src/llgr_pkg.sv
src/llgr_item_if.sv
src/llgr_result_if.sv
src/llgr_cfg_if.sv
src/llgr_ram.sv
src/linked_list_group_reverse.sv
src/llgr_checker.sv
verif/llgr_order_checker.sv
verif/tb.sv
